[src/dip_pkg.sv]
// Package for the decimal integer text parser.
// Holds the scan phase type, character constants and the per-item result type.
`timescale 1ns / 1ps

package dip_pkg;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_IGNORE = 3'd4,
    PH_FAILED = 3'd5
  } scan_phase_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [63:0] S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MIN_M = 64'h8000_0000_0000_0000;

  localparam logic CFG_SIGNED_MODE      = 1'b0;
  localparam logic CFG_TRAILING_ALLOWED = 1'b1;

  typedef struct packed {
    logic        ok;
    logic [63:0] value;
  } parse_result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

[src/dip_scan.sv]
// Scan state of the parser: phase, accumulator and minus flag, with the
// per-byte next-state logic and the end-of-text result. Uses dip_pkg.
`timescale 1ns / 1ps

module dip_scan (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic [7:0]             text_byte,
  input  logic                   signed_mode,
  input  logic                   trailing_allowed,
  output dip_pkg::parse_result_t result
);
  import dip_pkg::*;

  scan_phase_t phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        minus_r, minus_nxt;

  logic [67:0] acc_mul;
  logic        acc_ovf;
  logic        dig, ws, nul;
  logic        ok_base, ok;
  logic [63:0] val;

  assign dig = is_digit(text_byte);
  assign ws  = is_ws(text_byte);
  assign nul = (text_byte == CH_NUL);

  // acc * 10 + digit, overflow when anything lands above bit 63
  assign acc_mul = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                 + {64'd0, text_byte[3:0]};
  assign acc_ovf = |acc_mul[67:64];

  always_comb begin
    ok_base = (phase_r == PH_DIGITS) || (phase_r == PH_TRAIL) || (phase_r == PH_IGNORE);
    ok      = ok_base;
    val     = acc_r;
    if (minus_r) begin
      if (acc_r <= INT64_MIN_M) begin
        val = 64'd0 - acc_r;
      end else begin
        ok = 1'b0;
      end
    end else if (signed_mode && (acc_r > S64_MAX)) begin
      ok = 1'b0;
    end
    result.ok    = ok;
    result.value = ok ? val : 64'd0;
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    minus_nxt = minus_r;
    if (nul) begin
      phase_nxt = PH_LEAD;
      acc_nxt   = 64'd0;
      minus_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        PH_LEAD: begin
          if (ws) begin
            phase_nxt = PH_LEAD;
          end else if (text_byte == CH_PLUS) begin
            phase_nxt = PH_SIGN;
          end else if ((text_byte == CH_MINUS) && signed_mode) begin
            minus_nxt = 1'b1;
            phase_nxt = PH_SIGN;
          end else if (dig) begin
            acc_nxt   = acc_mul[63:0];
            phase_nxt = acc_ovf ? PH_FAILED : PH_DIGITS;
          end else begin
            phase_nxt = PH_FAILED;
          end
        end
        PH_SIGN: begin
          if (dig) begin
            acc_nxt   = acc_mul[63:0];
            phase_nxt = acc_ovf ? PH_FAILED : PH_DIGITS;
          end else begin
            phase_nxt = PH_FAILED;
          end
        end
        PH_DIGITS: begin
          if (dig) begin
            acc_nxt = acc_mul[63:0];
            if (acc_ovf) begin
              phase_nxt = PH_FAILED;
            end
          end else if (trailing_allowed) begin
            phase_nxt = PH_IGNORE;
          end else if (ws) begin
            phase_nxt = PH_TRAIL;
          end else begin
            phase_nxt = PH_FAILED;
          end
        end
        PH_TRAIL: begin
          if (!ws) begin
            phase_nxt = PH_FAILED;
          end
        end
        PH_IGNORE: begin
          phase_nxt = PH_IGNORE;
        end
        default: begin
          phase_nxt = PH_FAILED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      acc_r   <= 64'd0;
      minus_r <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      minus_r <= minus_nxt;
    end
  end

endmodule

[src/decimal_int64_text_parser_unit.sv]
// Decimal int64 text parser, top level: input register, configuration
// registers, scan state (dip_scan) and result register. Uses dip_pkg.
//
// Usage:
//   Text enters one byte per item on in_text_byte (in_valid / in_stall).
//   A NUL byte ends the text and produces exactly one result item on
//   out_parse_ok / out_parsed_value (out_valid / out_stall); other bytes
//   produce none. The value is two's complement in signed mode, zero on
//   failure.
//   cfg_we writes cfg_wdata to register cfg_index: 0 signed mode,
//   1 trailing text allowed. Write only while no text is in flight.
//   Throughput: one byte per cycle while in_stall is low. A NUL passes
//   through the input register, then the result register, which drives
//   out_valid; the times-ten add with overflow test feeds the scan state.
//   When out_stall holds a pending result, bytes that are not NUL keep
//   flowing; a NUL waits in the input register and in_stall rises.
//   Reset clears the valid flags of both registers, the scan state and the configuration.
`timescale 1ns / 1ps

module decimal_int64_text_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_parse_ok,
  output logic [63:0] out_parsed_value,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);
  import dip_pkg::*;

  logic          in_valid_r;
  logic [7:0]    byte_r;
  logic          signed_mode_r;
  logic          trailing_allowed_r;
  logic          out_valid_r;
  logic          out_ok_r;
  logic [63:0]   out_value_r;
  logic          byte_nul;
  logic          advance;
  logic          out_free;
  parse_result_t res;

  assign byte_nul = (byte_r == CH_NUL);
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && (!byte_nul || out_free);
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r      <= 1'b0;
      trailing_allowed_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIGNED_MODE:      signed_mode_r      <= cfg_wdata;
        CFG_TRAILING_ALLOWED: trailing_allowed_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dip_scan u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (advance),
    .text_byte        (byte_r),
    .signed_mode      (signed_mode_r),
    .trailing_allowed (trailing_allowed_r),
    .result           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && byte_nul) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && byte_nul) begin
      out_ok_r    <= res.ok;
      out_value_r <= res.value;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_parse_ok     = out_ok_r;
  assign out_parsed_value = out_value_r;

endmodule

[tb/dip_result_checker.sv]
// Result checker for the decimal int64 text parser: follows the text bytes and
// register writes, keeps its own parse state and compares every result item.
// Uses dip_pkg for the phase type, character codes and the result struct.
`timescale 1ns / 1ps

module dip_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_parse_ok,
  input  logic [63:0] out_parsed_value,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata,
  output int          error_count,
  output int          results_owed
);
  import dip_pkg::*;

  scan_phase_t   phase;
  logic [63:0]   acc;
  logic          minus_seen;
  logic          signed_mode;
  logic          trail_ok;
  parse_result_t owed_results[$];
  parse_result_t want;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_val);
    $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, exp_val);
    error_count++;
  endtask

  function automatic logic blank_char(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // times ten plus digit; anything past 64 bits fails the parse
  task automatic take_digit(input logic [7:0] c);
    logic [67:0] wide;
    wide = {4'd0, acc} * 68'd10 + (c - CH_ZERO);
    if (wide[67:64] != 4'd0) begin
      phase = PH_FAILED;
    end else begin
      acc   = wide[63:0];
      phase = PH_DIGITS;
    end
  endtask

  task automatic scan_byte(input logic [7:0] c);
    parse_result_t r;
    logic          ok;
    logic [63:0]   v;
    if (c == CH_NUL) begin
      ok = (phase == PH_DIGITS) || (phase == PH_TRAIL) || (phase == PH_IGNORE);
      v  = acc;
      if (ok && (signed_mode || minus_seen)) begin
        if (minus_seen) begin
          if (v <= INT64_MIN_M) v = -v;
          else ok = 1'b0;
        end else if (v > S64_MAX) begin
          ok = 1'b0;
        end
      end
      r.ok    = ok;
      r.value = ok ? v : 64'd0;
      owed_results.push_back(r);
      phase      = PH_LEAD;
      acc        = '0;
      minus_seen = 1'b0;
    end else begin
      case (phase)
        PH_LEAD: begin
          if (blank_char(c)) begin
          end else if (c == CH_PLUS) begin
            phase = PH_SIGN;
          end else if (c == CH_MINUS && signed_mode) begin
            minus_seen = 1'b1;
            phase      = PH_SIGN;
          end else if (digit_char(c)) begin
            take_digit(c);
          end else begin
            phase = PH_FAILED;
          end
        end
        PH_SIGN: begin
          if (digit_char(c)) take_digit(c);
          else phase = PH_FAILED;
        end
        PH_DIGITS: begin
          if (digit_char(c)) take_digit(c);
          else if (trail_ok) phase = PH_IGNORE;
          else if (blank_char(c)) phase = PH_TRAIL;
          else phase = PH_FAILED;
        end
        PH_TRAIL: begin
          if (!blank_char(c)) phase = PH_FAILED;
        end
        PH_IGNORE: begin
        end
        default: begin
          phase = PH_FAILED;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase       = PH_LEAD;
      acc         = '0;
      minus_seen  = 1'b0;
      signed_mode = 1'b0;
      trail_ok    = 1'b0;
      owed_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          report("unexpected result item", out_parsed_value, 64'd0);
        end else begin
          want = owed_results.pop_front();
          if (out_parse_ok !== want.ok)
            report("parse_ok", {63'd0, out_parse_ok}, {63'd0, want.ok});
          if (out_parsed_value !== want.value)
            report("parsed_value", out_parsed_value, want.value);
        end
      end
      if (in_valid && !in_stall) scan_byte(in_text_byte);
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIGNED_MODE:      signed_mode = cfg_wdata;
          CFG_TRAILING_ALLOWED: trail_ok    = cfg_wdata;
          default: ;
        endcase
      end
    end
    results_owed = owed_results.size();
  end

endmodule

[tb/tb.sv]
// Testbench top for decimal_int64_text_parser_unit: clock, reset, text and
// register stimulus, receiver stalls and the verdict. Checking is done by
// dip_result_checker; types and character codes come from dip_pkg.
`timescale 1ns / 1ps

module tb;
  import dip_pkg::*;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_text_byte = 8'd0;
  logic        out_stall    = 1'b0;
  logic        cfg_we       = 1'b0;
  logic        cfg_index    = 1'b0;
  logic        cfg_wdata    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_parse_ok;
  logic [63:0] out_parsed_value;
  int          error_count;
  int          results_owed;

  logic [7:0]  text_buf[$];
  int          bytes_sent     = 0;
  int          send_idle_mode = 0;
  int          recv_idle_mode = 0;
  bit          long_hold_req  = 1'b0;

  decimal_int64_text_parser_unit u_dut (.*);
  dip_result_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** decimal_int64_text_parser_unit: FAILED **");
    $finish;
  end

  // 0: never idle, 1: 0..16 every item, 2: occasional gaps
  function automatic int draw_gap(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 16);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  function automatic logic [7:0] blank_byte();
    int r = $urandom_range(8, 13);
    return (r == 8) ? CH_SPACE : 8'(r);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(send_idle_mode);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i]);
    send_byte(CH_NUL);
  endtask

  task automatic add_string(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic send_string(input string s);
    text_buf.delete();
    add_string(s);
    send_text();
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_mode(input logic sgn, input logic trl);
    drain();
    write_reg(CFG_SIGNED_MODE, sgn);
    write_reg(CFG_TRAILING_ALLOWED, trl);
  endtask

  task automatic make_random_text();
    logic [63:0] v;
    string       digits;
    text_buf.delete();
    case ($urandom_range(0, 9))
      0: begin
        repeat ($urandom_range(0, 12)) text_buf.push_back(8'($urandom_range(1, 255)));
      end
      1: begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0:       text_buf.push_back(CH_PLUS);
            1:       text_buf.push_back(CH_MINUS);
            default: text_buf.push_back(blank_byte());
          endcase
        end
      end
      default: begin
        repeat ($urandom_range(0, 2)) text_buf.push_back(blank_byte());
        case ($urandom_range(0, 5))
          0:       text_buf.push_back(CH_PLUS);
          1, 2:    text_buf.push_back(CH_MINUS);
          default: ;
        endcase
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 3)) text_buf.push_back(CH_ZERO);
        case ($urandom_range(0, 5))
          0:       v = {$urandom, $urandom};
          1:       v = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
          2:       v = INT64_MIN_M + $urandom_range(0, 3) - 64'd2;
          3:       v = $urandom_range(0, 999);
          4:       v = {$urandom, $urandom} >> $urandom_range(0, 63);
          default: v = $urandom_range(0, 99999);
        endcase
        digits = $sformatf("%0d", v);
        // an extra digit sometimes pushes the value past 64 bits
        if ($urandom_range(0, 9) == 0) digits = {digits, "7"};
        add_string(digits);
        case ($urandom_range(0, 7))
          0: repeat ($urandom_range(1, 3)) text_buf.push_back(blank_byte());
          1: text_buf.push_back(8'($urandom_range(1, 255)));
          2: begin
            text_buf.push_back(blank_byte());
            text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          end
          3: repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom_range(33, 126)));
          default: ;
        endcase
        if ($urandom_range(0, 9) == 0)
          text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(1, 255));
      end
    endcase
  endtask

  // receiver: may stall before each result item, one long hold on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end else begin
        n = draw_gap(recv_idle_mode);
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int goal;
    int waited;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // unsigned, whitespace only after digits
    send_string("");
    send_string("0");
    send_string("18446744073709551615");
    send_string("18446744073709551616");
    send_string("+5");
    send_string("-5");
    send_string("12x");
    send_string("+");
    send_string("1 2");
    text_buf.delete();
    text_buf.push_back(CH_SPACE);
    for (int c = 9; c <= 13; c++) text_buf.push_back(8'(c));
    add_string("42");
    text_buf.push_back(CH_TAB);
    text_buf.push_back(CH_CR);
    send_text();
    text_buf.delete();
    text_buf.push_back(8'hFF);
    add_string("1");
    send_text();

    set_mode(1'b1, 1'b0);
    send_string("-9223372036854775808");
    send_string("-9223372036854775809");
    send_string("9223372036854775807");
    send_string("9223372036854775808");
    send_string("--1");
    send_string("-0");

    set_mode(1'b0, 1'b1);
    send_string("12abc");
    send_string("99999999999999999999x");
    send_string("+x");
    text_buf.delete();
    add_string("7");
    text_buf.push_back(8'hFF);
    send_text();

    // back-to-back short texts against a long receiver hold
    drain();
    send_idle_mode = 0;
    long_hold_req  = 1'b1;
    repeat (40) begin
      text_buf.delete();
      text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      send_text();
    end
    drain();

    goal = bytes_sent;
    for (int p = 0; p < 6; p++) begin
      set_mode(p[0], p[1]);
      send_idle_mode = $urandom_range(0, 2);
      recv_idle_mode = $urandom_range(0, 2);
      goal += 222;
      while (bytes_sent < goal) begin
        make_random_text();
        send_text();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (results_owed != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (error_count == 0 && results_owed == 0) begin
      $display("** decimal_int64_text_parser_unit: PASSED **");
    end else begin
      $display("** decimal_int64_text_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
